// ----- rtl/core/led_heartbeat_pwm_sequencer_core_assert.svh -----
// ----------------------------------------------------------------------------
// led heartbeat pwm sequencer assertion macros
// concurrent assertion shorthands shared by the core files
// ----------------------------------------------------------------------------
`ifndef LED_HEARTBEAT_PWM_SEQUENCER_CORE_ASSERT_SVH
`define LED_HEARTBEAT_PWM_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LHPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lhps assertion failed");

// next-cycle implication, disabled during reset
`define LHPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lhps assertion failed");

`endif

// ----- rtl/core/lhps_pkg.sv -----
// ----------------------------------------------------------------------------
// lhps_pkg
// shared types, register indexes, segment codes and gamma table
// ----------------------------------------------------------------------------
`default_nettype none

package lhps_pkg;

    localparam int CFG_W   = 20;
    localparam int IDX_W_C = 8;

    // register indexes on the configuration channel
    localparam logic [IDX_W_C-1:0] REG_PRESS_MIN = 8'd0;
    localparam logic [IDX_W_C-1:0] REG_SLOW_RAMP = 8'd1;
    localparam logic [IDX_W_C-1:0] REG_FAST_RAMP = 8'd2;
    localparam logic [IDX_W_C-1:0] REG_BEAT_RISE = 8'd3;
    localparam logic [IDX_W_C-1:0] REG_BEAT_FALL = 8'd4;
    localparam logic [IDX_W_C-1:0] REG_REST_SLOW = 8'd5;
    localparam logic [IDX_W_C-1:0] REG_REST_MID  = 8'd6;
    localparam logic [IDX_W_C-1:0] REG_REST_FAST = 8'd7;

    // pattern modes
    localparam logic [2:0] MODE_HOLD   = 3'd0;
    localparam logic [2:0] MODE_SLOW   = 3'd1;
    localparam logic [2:0] MODE_FAST   = 3'd2;
    localparam logic [2:0] MODE_BEAT_S = 3'd3;
    localparam logic [2:0] MODE_BEAT_M = 3'd4;
    localparam logic [2:0] MODE_LAST   = 3'd5;

    typedef enum logic [2:0] {
        SEG_IDLE = 3'd0,
        SEG_RISE = 3'd1,
        SEG_UPPER = 3'd2,
        SEG_FALL = 3'd3,
        SEG_REST = 3'd4
    } seg_t;

    typedef struct packed {
        logic [7:0]       press_min;
        logic [CFG_W-1:0] slow_ramp;
        logic [CFG_W-1:0] fast_ramp;
        logic [CFG_W-1:0] beat_rise;
        logic [CFG_W-1:0] beat_fall;
        logic [CFG_W-1:0] rest_slow;
        logic [CFG_W-1:0] rest_mid;
        logic [CFG_W-1:0] rest_fast;
    } cfg_t;

    localparam logic [7:0] PRESS_MAX = 8'd255;

    localparam logic [7:0] GAMMA_LUT [32] = '{
        8'd0,   8'd0,   8'd2,   8'd3,   8'd6,   8'd8,   8'd12,  8'd15,
        8'd20,  8'd24,  8'd30,  8'd35,  8'd42,  8'd48,  8'd56,  8'd63,
        8'd71,  8'd80,  8'd89,  8'd99,  8'd109, 8'd120, 8'd131, 8'd143,
        8'd155, 8'd168, 8'd181, 8'd195, 8'd209, 8'd224, 8'd239, 8'd255
    };

    // gamma lookup, indexes past the table read the last entry
    function automatic logic [7:0] gamma_at(input logic [7:0] idx);
        logic [4:0] i;
        i = (idx > 8'd31) ? 5'd31 : idx[4:0];
        return GAMMA_LUT[i];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lhps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lhps_cfg_regs
// configuration register file, written through the index/data channel
// ----------------------------------------------------------------------------
`default_nettype none

module lhps_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    input  wire logic [7:0]                  cfg_index,
    input  wire logic [lhps_pkg::CFG_W-1:0]  cfg_data,
    output lhps_pkg::cfg_t                   cfg
);

    lhps_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_min <= 8'd21;
            cfg_reg.slow_ramp <= 20'd800;
            cfg_reg.fast_ramp <= 20'd400;
            cfg_reg.beat_rise <= 20'd10000;
            cfg_reg.beat_fall <= 20'd5000;
            cfg_reg.rest_slow <= 20'd1000000;
            cfg_reg.rest_mid  <= 20'd666666;
            cfg_reg.rest_fast <= 20'd333333;
        end else if (cfg_valid) begin
            case (cfg_index)
                lhps_pkg::REG_PRESS_MIN: cfg_reg.press_min <= cfg_data[7:0];
                lhps_pkg::REG_SLOW_RAMP: cfg_reg.slow_ramp <= cfg_data;
                lhps_pkg::REG_FAST_RAMP: cfg_reg.fast_ramp <= cfg_data;
                lhps_pkg::REG_BEAT_RISE: cfg_reg.beat_rise <= cfg_data;
                lhps_pkg::REG_BEAT_FALL: cfg_reg.beat_fall <= cfg_data;
                lhps_pkg::REG_REST_SLOW: cfg_reg.rest_slow <= cfg_data;
                lhps_pkg::REG_REST_MID:  cfg_reg.rest_mid  <= cfg_data;
                lhps_pkg::REG_REST_FAST: cfg_reg.rest_fast <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lhps_seq.sv -----
// ----------------------------------------------------------------------------
// lhps_seq
// pattern state registers and single-tick next-state logic
// ----------------------------------------------------------------------------
`default_nettype none

module lhps_seq #(
    parameter int TABLE_DEPTH = 32,
    parameter int TIMER_WIDTH = 20
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire logic          pressed,
    input  wire lhps_pkg::cfg_t cfg,
    output logic [7:0]         duty_next,
    output logic [2:0]         mode_next
);

    localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
    localparam int HALF  = TABLE_DEPTH / 2;
    localparam logic [IDX_W-1:0] IDX_HALF   = IDX_W'(HALF);
    localparam logic [IDX_W-1:0] IDX_HALF_M = IDX_W'(HALF - 1);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_DEPTH  = IDX_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);
    localparam logic [TIMER_WIDTH-1:0] TMR_ONE = TIMER_WIDTH'(1);

    logic [2:0]             mode_reg;
    logic [IDX_W-1:0]       idx_reg,   idx_next;
    lhps_pkg::seg_t         seg_reg,   seg_next;
    logic                   beat_reg,  beat_next;
    logic [TIMER_WIDTH-1:0] tmr_reg,   tmr_next;
    logic [7:0]             pc_reg,    pc_next;
    logic                   hold_reg,  hold_next;
    logic [7:0]             duty_reg;

    logic [lhps_pkg::CFG_W-1:0] raw_len, raw_rest;
    logic [TIMER_WIDTH-1:0]     cur_len, rest_len, step_len;
    logic [IDX_W-1:0]           top, idx_clamp;
    logic                       is_beat, down, load, start;

    // saturate a register value into the timer width
    function automatic logic [TIMER_WIDTH-1:0] cap(input logic [lhps_pkg::CFG_W-1:0] v);
        logic [TIMER_WIDTH-1:0] r;
        r = TIMER_WIDTH'(v);
        if ((v >> TIMER_WIDTH) != '0) r = '1;
        return r;
    endfunction

    // segment lengths for the current mode
    always_comb begin
        case (mode_reg)
            lhps_pkg::MODE_BEAT_S: raw_rest = cfg.rest_slow;
            lhps_pkg::MODE_BEAT_M: raw_rest = cfg.rest_mid;
            default:               raw_rest = cfg.rest_fast;
        endcase
        if (mode_reg == lhps_pkg::MODE_SLOW)      raw_len = cfg.slow_ramp;
        else if (mode_reg == lhps_pkg::MODE_FAST) raw_len = cfg.fast_ramp;
        else if (seg_reg == lhps_pkg::SEG_RISE)   raw_len = cfg.beat_rise;
        else                                      raw_len = cfg.beat_fall;
        rest_len = cap(raw_rest);
        step_len = cap(raw_len);
        if (step_len == '0) step_len = TMR_ONE;
        cur_len = (seg_reg == lhps_pkg::SEG_REST) ? rest_len : step_len;
    end

    always_comb begin
        is_beat = mode_reg >= lhps_pkg::MODE_BEAT_S;
        down    = (seg_reg == lhps_pkg::SEG_UPPER && !is_beat) || seg_reg == lhps_pkg::SEG_FALL;
        top     = (mode_reg == lhps_pkg::MODE_SLOW) ? IDX_HALF_M : IDX_LAST;
        if (seg_reg == lhps_pkg::SEG_RISE && is_beat) top = IDX_HALF_M;

        mode_next = mode_reg;
        idx_next  = idx_reg;
        seg_next  = seg_reg;
        beat_next = beat_reg;
        tmr_next  = tmr_reg;
        pc_next   = pc_reg;
        hold_next = hold_reg;
        load      = 1'b0;
        start     = 1'b1;

        // step timing and advance through the pattern
        if (seg_reg != lhps_pkg::SEG_IDLE) begin
            if (tmr_reg < cur_len) begin
                tmr_next = tmr_reg + TMR_ONE;
            end else if (seg_reg == lhps_pkg::SEG_REST) begin
                seg_next  = lhps_pkg::SEG_IDLE;
                beat_next = 1'b0;
                tmr_next  = '0;
            end else if (down ? (idx_reg > IDX_ONE) : (idx_reg < top)) begin
                idx_next = down ? idx_reg - IDX_ONE : idx_reg + IDX_ONE;
                load     = 1'b1;
                tmr_next = TMR_ONE;
            end else if (!is_beat) begin
                if (seg_reg == lhps_pkg::SEG_RISE) begin
                    seg_next = lhps_pkg::SEG_UPPER;
                    idx_next = (mode_reg == lhps_pkg::MODE_SLOW) ? IDX_HALF : IDX_DEPTH;
                    load     = 1'b1;
                    tmr_next = TMR_ONE;
                end else begin
                    seg_next = lhps_pkg::SEG_IDLE;
                    tmr_next = '0;
                end
            end else if (seg_reg == lhps_pkg::SEG_RISE) begin
                seg_next = lhps_pkg::SEG_UPPER;
                idx_next = IDX_HALF;
                load     = 1'b1;
                tmr_next = TMR_ONE;
            end else if (seg_reg == lhps_pkg::SEG_UPPER) begin
                seg_next = lhps_pkg::SEG_FALL;
                idx_next = IDX_DEPTH;
                load     = 1'b1;
                tmr_next = TMR_ONE;
            end else if (!beat_reg) begin
                beat_next = 1'b1;
                seg_next  = lhps_pkg::SEG_RISE;
                idx_next  = '0;
                load      = 1'b1;
                tmr_next  = TMR_ONE;
            end else begin
                // into the rest, or straight out when the rest is empty
                idx_next = '0;
                if (rest_len == '0) begin
                    seg_next  = lhps_pkg::SEG_IDLE;
                    beat_next = 1'b0;
                    tmr_next  = '0;
                end else begin
                    seg_next = lhps_pkg::SEG_REST;
                    tmr_next = TMR_ONE;
                end
            end
        end

        // boundary tick: button handling and pattern start
        if (seg_next == lhps_pkg::SEG_IDLE) begin
            if (pressed) begin
                hold_next = 1'b1;
                if (pc_reg != lhps_pkg::PRESS_MAX) pc_next = pc_reg + 8'd1;
                start = 1'b0;
            end else if (hold_reg) begin
                if (pc_reg >= cfg.press_min)
                    mode_next = (mode_reg >= lhps_pkg::MODE_LAST) ? lhps_pkg::MODE_HOLD
                                                                  : mode_reg + 3'd1;
                hold_next = 1'b0;
                pc_next   = '0;
            end
            if (start && mode_next >= lhps_pkg::MODE_SLOW && mode_next <= lhps_pkg::MODE_LAST) begin
                beat_next = 1'b0;
                seg_next  = lhps_pkg::SEG_RISE;
                idx_next  = '0;
                load      = 1'b1;
                tmr_next  = TMR_ONE;
            end
        end

        idx_clamp = (idx_next > IDX_LAST) ? IDX_LAST : idx_next;
        duty_next = load ? lhps_pkg::gamma_at(8'(idx_clamp)) : duty_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= lhps_pkg::MODE_HOLD;
            idx_reg  <= '0;
            seg_reg  <= lhps_pkg::SEG_IDLE;
            beat_reg <= 1'b0;
            tmr_reg  <= '0;
            pc_reg   <= '0;
            hold_reg <= 1'b0;
            duty_reg <= '0;
        end else if (step_en) begin
            mode_reg <= mode_next;
            idx_reg  <= idx_next;
            seg_reg  <= seg_next;
            beat_reg <= beat_next;
            tmr_reg  <= tmr_next;
            pc_reg   <= pc_next;
            hold_reg <= hold_next;
            duty_reg <= duty_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/led_heartbeat_pwm_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// led_heartbeat_pwm_sequencer_core
// breathing / double-heartbeat led duty sequencer with gamma table
// ----------------------------------------------------------------------------
// usage:
//   one item on the s_ channel is one 1 us tick carrying the button level;
//   every item yields exactly one item on the m_ channel with the duty to
//   drive this tick and the selected mode.
//   the cfg channel writes one of eight configuration registers by index; it is
//   ready whenever out of reset, indexes past seven are dropped. write only while idle.
// path: an accepted tick is held in the input register, then the step logic
//   updates the pattern state and loads the output register that offers it.
// throughput: one tick per cycle unless m_tready holds the result; the
//   pattern state update is combinational: timer compare, index step, gamma lookup.
// reset: aresetn (synchronous, low) returns to mode 0, duty 0, pattern
//   idle and restores the register defaults; both pipeline slots empty.
// stall: when m_tready is low the result holds, one more tick can wait in
//   the input register, and s_tready drops only when both slots are full.
// ----------------------------------------------------------------------------
`default_nettype none

module led_heartbeat_pwm_sequencer_core #(
    parameter int TABLE_DEPTH = 32,
    parameter int TIMER_WIDTH = 20
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // tick input
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [0] button_pressed
    // result output
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata,   // [7:0] duty, [10:8] mode_now
    // configuration writes
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [7:0]                 cfg_index,
    input  wire logic [lhps_pkg::CFG_W-1:0] cfg_data
);

`include "led_heartbeat_pwm_sequencer_core_assert.svh"

    logic           in_valid_reg;
    logic           in_btn_reg;
    logic           out_valid_reg;
    logic [7:0]     out_duty_reg;
    logic [2:0]     out_mode_reg;
    logic           advance;
    logic [7:0]     duty_next;
    logic [2:0]     mode_next;
    lhps_pkg::cfg_t cfg;

    // the held tick moves on when the output slot is free or being emptied
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    // nothing is taken while reset is held
    assign s_tready  = aresetn && (!in_valid_reg || advance);
    assign cfg_ready = aresetn;

    lhps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lhps_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .pressed   (in_btn_reg),
        .cfg       (cfg),
        .duty_next (duty_next),
        .mode_next (mode_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_btn_reg <= s_tdata[0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_duty_reg <= duty_next;
            out_mode_reg <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_mode_reg, out_duty_reg};

    // a processed tick always lands in the output slot
    `LHPS_ASSERT_NEXT(a_adv_fills_out, aclk, aresetn, advance, m_tvalid)
    // a held tick that cannot move stays held
    `LHPS_ASSERT_NEXT(a_in_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)
    // the mode never leaves the six defined patterns
    `LHPS_ASSERT_NOW(a_mode_range, aclk, aresetn, m_tvalid, m_tdata[10:8] <= 3'd5)

endmodule

`default_nettype wire

// ----- sim/led_heartbeat_pwm_sequencer_core_test.sv -----
// ----------------------------------------------------------------------------
// led_heartbeat_pwm_sequencer_core_test
// self-checking bench: tick stream in, duty and mode stream out, compared
// item by item against a behavioral model of the sequencer kept in the bench
// ----------------------------------------------------------------------------

module led_heartbeat_pwm_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH     = 32;
    localparam int HALF_DEPTH    = TBL_DEPTH / 2;
    localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int LONG_STALL    = 40;    // receiver hold-off, block fills up
    localparam int SETTLE_CYCLES = 4;     // input and output registers plus margin
    localparam int PRESS_CAP     = 400;   // longest button hold in random part
    localparam int STALL_PHASE   = 3;
    localparam int PAUSE_PHASE   = 2;
    localparam int NUM_PHASES    = 7;

    // indexes past the register file, writes must be dropped
    localparam logic [7:0] REG_UNUSED_LO = 8'd8;
    localparam logic [7:0] REG_UNUSED_HI = 8'd255;

    localparam logic [lhps_pkg::CFG_W-1:0] SPAN_MAX = '1;

    // brightness curve, index past the end reads the last entry
    localparam logic [7:0] CURVE [TBL_DEPTH] = '{
        8'd0,   8'd0,   8'd2,   8'd3,   8'd6,   8'd8,   8'd12,  8'd15,
        8'd20,  8'd24,  8'd30,  8'd35,  8'd42,  8'd48,  8'd56,  8'd63,
        8'd71,  8'd80,  8'd89,  8'd99,  8'd109, 8'd120, 8'd131, 8'd143,
        8'd155, 8'd168, 8'd181, 8'd195, 8'd209, 8'd224, 8'd239, 8'd255
    };

    typedef struct packed {
        logic [7:0] duty;
        logic [2:0] mode;
    } tick_out_t;

    // one directed item; reload marks a register load before it
    typedef struct packed {
        logic       reload;
        logic       pressed;
        logic       typed;
        logic [7:0] duty;
        logic [2:0] mode;
    } stim_row_t;

    typedef struct {
        logic [7:0]                 press_min;
        logic [lhps_pkg::CFG_W-1:0] slow_ramp;
        logic [lhps_pkg::CFG_W-1:0] fast_ramp;
        logic [lhps_pkg::CFG_W-1:0] beat_rise;
        logic [lhps_pkg::CFG_W-1:0] beat_fall;
        logic [lhps_pkg::CFG_W-1:0] rest_slow;
        logic [lhps_pkg::CFG_W-1:0] rest_mid;
        logic [lhps_pkg::CFG_W-1:0] rest_fast;
        int                         items;
        bit                         long_ok;
        bit                         quiet;
    } phase_set_t;

    // ------------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    wire                        s_tready;
    logic [7:0]                 s_tdata   = '0;
    wire                        m_tvalid;
    logic                       m_tready  = 1'b0;
    wire  [15:0]                m_tdata;
    logic                       cfg_valid = 1'b0;
    wire                        cfg_ready;
    logic [7:0]                 cfg_index = '0;
    logic [lhps_pkg::CFG_W-1:0] cfg_data  = '0;

    led_heartbeat_pwm_sequencer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [0] button_pressed
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] duty, [10:8] mode_now
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // bench control
    // ------------------------------------------------------------------------
    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    bit stall_req     = 1'b0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    tick_out_t due_outputs [$];  // duty/mode owed by the block, oldest first

    // ------------------------------------------------------------------------
    // sequencer model state and register shadow
    // ------------------------------------------------------------------------
    lhps_pkg::cfg_t             cfg_shadow;
    logic [2:0]                 mode_q;
    logic [5:0]                 idx_q;
    lhps_pkg::seg_t             seg_q;
    logic                       beat_q;
    logic [lhps_pkg::CFG_W-1:0] timer_q;
    logic [7:0]                 press_q;
    logic                       holding_q;
    logic [7:0]                 duty_q;

    function automatic void restore_defaults();
        cfg_shadow.press_min = 8'd21;
        cfg_shadow.slow_ramp = lhps_pkg::CFG_W'(800);
        cfg_shadow.fast_ramp = lhps_pkg::CFG_W'(400);
        cfg_shadow.beat_rise = lhps_pkg::CFG_W'(10000);
        cfg_shadow.beat_fall = lhps_pkg::CFG_W'(5000);
        cfg_shadow.rest_slow = lhps_pkg::CFG_W'(1000000);
        cfg_shadow.rest_mid  = lhps_pkg::CFG_W'(666666);
        cfg_shadow.rest_fast = lhps_pkg::CFG_W'(333333);
        mode_q    = lhps_pkg::MODE_HOLD;
        idx_q     = '0;
        seg_q     = lhps_pkg::SEG_IDLE;
        beat_q    = 1'b0;
        timer_q   = '0;
        press_q   = '0;
        holding_q = 1'b0;
        duty_q    = '0;
    endfunction

    function automatic void write_shadow(input logic [7:0] idx,
                                         input logic [lhps_pkg::CFG_W-1:0] data);
        case (idx)
            lhps_pkg::REG_PRESS_MIN: cfg_shadow.press_min = data[7:0];
            lhps_pkg::REG_SLOW_RAMP: cfg_shadow.slow_ramp = data;
            lhps_pkg::REG_FAST_RAMP: cfg_shadow.fast_ramp = data;
            lhps_pkg::REG_BEAT_RISE: cfg_shadow.beat_rise = data;
            lhps_pkg::REG_BEAT_FALL: cfg_shadow.beat_fall = data;
            lhps_pkg::REG_REST_SLOW: cfg_shadow.rest_slow = data;
            lhps_pkg::REG_REST_MID:  cfg_shadow.rest_mid  = data;
            lhps_pkg::REG_REST_FAST: cfg_shadow.rest_fast = data;
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] curve_at(input logic [5:0] idx);
        return (idx > 6'(TBL_DEPTH - 1)) ? CURVE[TBL_DEPTH-1] : CURVE[idx[4:0]];
    endfunction

    // ticks the current step lasts; rest may be zero, ramp steps never are
    function automatic logic [lhps_pkg::CFG_W-1:0] step_span();
        logic [lhps_pkg::CFG_W-1:0] len;
        if (seg_q == lhps_pkg::SEG_REST) begin
            if (mode_q == lhps_pkg::MODE_BEAT_S) return cfg_shadow.rest_slow;
            if (mode_q == lhps_pkg::MODE_BEAT_M) return cfg_shadow.rest_mid;
            return cfg_shadow.rest_fast;
        end
        if (mode_q == lhps_pkg::MODE_SLOW)         len = cfg_shadow.slow_ramp;
        else if (mode_q == lhps_pkg::MODE_FAST)    len = cfg_shadow.fast_ramp;
        else if (seg_q == lhps_pkg::SEG_RISE)      len = cfg_shadow.beat_rise;
        else                                       len = cfg_shadow.beat_fall;
        return (len == '0) ? lhps_pkg::CFG_W'(1) : len;
    endfunction

    // a zero rest ends the pattern right away
    function automatic void open_segment(input lhps_pkg::seg_t seg, input logic [5:0] idx);
        seg_q = seg;
        idx_q = idx;
        if (seg == lhps_pkg::SEG_REST && step_span() == '0) begin
            seg_q   = lhps_pkg::SEG_IDLE;
            beat_q  = 1'b0;
            timer_q = '0;
        end else begin
            if (seg != lhps_pkg::SEG_REST) duty_q = curve_at(idx);
            timer_q = lhps_pkg::CFG_W'(1);
        end
    endfunction

    function automatic void next_step();
        logic [5:0] top;
        logic       beat;
        logic       down;
        beat = (mode_q >= lhps_pkg::MODE_BEAT_S);
        down = (seg_q == lhps_pkg::SEG_UPPER && !beat) || seg_q == lhps_pkg::SEG_FALL;
        top  = (mode_q == lhps_pkg::MODE_SLOW || (beat && seg_q == lhps_pkg::SEG_RISE))
               ? 6'(HALF_DEPTH - 1) : 6'(TBL_DEPTH - 1);
        if (seg_q == lhps_pkg::SEG_REST) begin
            seg_q   = lhps_pkg::SEG_IDLE;
            beat_q  = 1'b0;
            timer_q = '0;
        end else if (down ? (idx_q > 6'd1) : (idx_q < top)) begin
            idx_q   = down ? idx_q - 6'd1 : idx_q + 6'd1;
            duty_q  = curve_at(idx_q);
            timer_q = lhps_pkg::CFG_W'(1);
        end else if (!beat) begin
            // ramp modes: turn around at the top, stop at the bottom
            if (seg_q == lhps_pkg::SEG_RISE)
                open_segment(lhps_pkg::SEG_UPPER,
                             (mode_q == lhps_pkg::MODE_SLOW) ? 6'(HALF_DEPTH) : 6'(TBL_DEPTH));
            else begin
                seg_q   = lhps_pkg::SEG_IDLE;
                timer_q = '0;
            end
        end else if (seg_q == lhps_pkg::SEG_RISE) begin
            open_segment(lhps_pkg::SEG_UPPER, 6'(HALF_DEPTH));
        end else if (seg_q == lhps_pkg::SEG_UPPER) begin
            open_segment(lhps_pkg::SEG_FALL, 6'(TBL_DEPTH));
        end else if (!beat_q) begin
            beat_q = 1'b1;
            open_segment(lhps_pkg::SEG_RISE, 6'd0);
        end else begin
            open_segment(lhps_pkg::SEG_REST, 6'd0);
        end
    endfunction

    // one tick through the sequencer model, gives the owed result
    function automatic tick_out_t sequencer_tick(input logic pressed);
        logic      start;
        tick_out_t res;
        if (seg_q != lhps_pkg::SEG_IDLE) begin
            if (timer_q < step_span()) timer_q++;
            else next_step();
        end
        if (seg_q == lhps_pkg::SEG_IDLE) begin
            start = 1'b1;
            if (pressed) begin
                holding_q = 1'b1;
                if (press_q != lhps_pkg::PRESS_MAX) press_q++;
                start = 1'b0;
            end else if (holding_q) begin
                if (press_q >= cfg_shadow.press_min)
                    mode_q = (mode_q >= lhps_pkg::MODE_LAST) ? lhps_pkg::MODE_HOLD
                                                             : mode_q + 3'd1;
                holding_q = 1'b0;
                press_q   = '0;
            end
            if (start && mode_q >= lhps_pkg::MODE_SLOW && mode_q <= lhps_pkg::MODE_LAST) begin
                beat_q = 1'b0;
                open_segment(lhps_pkg::SEG_RISE, 6'd0);
            end
        end
        res.duty = duty_q;
        res.mode = mode_q;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus tables
    // ------------------------------------------------------------------------
    // reset state first, then zero threshold / zero step / zero rest settings
    localparam stim_row_t DIRECTED_ROWS [18] = '{
        '{1'b0, 1'b0, 1'b1, 8'd0, lhps_pkg::MODE_HOLD},  // out of reset
        '{1'b0, 1'b1, 1'b1, 8'd0, lhps_pkg::MODE_HOLD},  // held, duty frozen
        '{1'b0, 1'b1, 1'b1, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b1, 8'd0, lhps_pkg::MODE_HOLD},  // short press, below threshold
        '{1'b1, 1'b1, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},  // reload, held one tick
        '{1'b0, 1'b0, 1'b1, 8'd0, lhps_pkg::MODE_SLOW},  // any press advances, ramp starts
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},  // zero step acts as one tick
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b1, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},  // press mid pattern is ignored
        '{1'b0, 1'b1, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD},
        '{1'b0, 1'b0, 1'b0, 8'd0, lhps_pkg::MODE_HOLD}
    };

    // entry 0 is the directed load, the rest are random phases
    phase_set_t phase_sets [NUM_PHASES] = '{
        '{8'd0,   '0, '0, '0, '0, '0, '0, '0, 0, 1'b0, 1'b0},
        '{8'd1,   20'd1, 20'd1, 20'd1, 20'd1, 20'd0, 20'd0, 20'd0, 180, 1'b0, 1'b0},
        '{8'd3,   20'd2, 20'd1, 20'd1, 20'd2, 20'd2, 20'd4, 20'd6, 160, 1'b0, 1'b0},
        '{8'd2,   20'd1, 20'd2, 20'd2, 20'd1, 20'd7, 20'd3, 20'd1, 120, 1'b0, 1'b0},
        '{8'd255, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 300, 1'b1, 1'b0},
        '{8'd21,  SPAN_MAX, SPAN_MAX, SPAN_MAX, SPAN_MAX,
                  SPAN_MAX, SPAN_MAX, SPAN_MAX, 40, 1'b0, 1'b0},
        '{8'd2,   20'd3, 20'd2, 20'd1, 20'd1, 20'd4, 20'd0, 20'd2, 80, 1'b0, 1'b1}
    };

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // result side: compare each accepted item with the oldest owed one
    always @(posedge aclk) begin
        tick_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_outputs.size() == 0) begin
                flag_mismatch("result with no tick pending", m_tdata[7:0], 8'd0);
            end else begin
                want = due_outputs.pop_front();
                if (m_tdata[7:0] !== want.duty)
                    flag_mismatch("duty", m_tdata[7:0], want.duty);
                if (m_tdata[10:8] !== want.mode)
                    flag_mismatch("mode", {5'd0, m_tdata[10:8]}, {5'd0, want.mode});
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: short random hold-offs, one long one on request
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [7:0] idx,
                                  input logic [lhps_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        write_shadow(idx, data);
    endtask

    task automatic load_settings(input phase_set_t p);
        write_register(lhps_pkg::REG_PRESS_MIN, lhps_pkg::CFG_W'(p.press_min));
        write_register(lhps_pkg::REG_SLOW_RAMP, p.slow_ramp);
        write_register(lhps_pkg::REG_FAST_RAMP, p.fast_ramp);
        write_register(lhps_pkg::REG_BEAT_RISE, p.beat_rise);
        write_register(lhps_pkg::REG_BEAT_FALL, p.beat_fall);
        write_register(lhps_pkg::REG_REST_SLOW, p.rest_slow);
        write_register(lhps_pkg::REG_REST_MID,  p.rest_mid);
        write_register(lhps_pkg::REG_REST_FAST, p.rest_fast);
        // out-of-range indexes, must not disturb anything
        write_register(REG_UNUSED_LO, lhps_pkg::CFG_W'($urandom));
        write_register(REG_UNUSED_HI, lhps_pkg::CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // offer one tick, wait for acceptance, record what it owes
    task automatic send_tick(input logic pressed, input logic typed, input tick_out_t typed_out);
        tick_out_t predicted;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pressed};
        do @(posedge aclk); while (!s_tready);
        predicted = sequencer_tick(pressed);
        due_outputs.push_back(typed ? typed_out : predicted);
    endtask

    // stop offering and let every owed result come out
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random phase: mostly whole presses timed against the pattern boundary,
    // with short glitches in between as noise
    task automatic run_phase(input int p);
        int   gap_left;
        int   press_goal;
        int   press_len;
        int   thr;
        bit   pressing;
        logic btn;
        gap_left   = $urandom_range(0, 12);
        pressing   = 1'b0;
        press_goal = 0;
        press_len  = 0;
        for (int n = 0; n < phase_sets[p].items; n++) begin
            thr = int'(cfg_shadow.press_min);
            if (p == STALL_PHASE && n == phase_sets[p].items / 3)
                stall_req = 1'b1;
            if (p == PAUSE_PHASE && n == phase_sets[p].items / 2) begin
                // sender waits for every owed result
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (due_outputs.size() != 0);
            end
            if (pressing) begin
                // release once the boundary has counted enough held ticks
                if ((holding_q && int'(press_q) >= press_goal) || press_len >= PRESS_CAP) begin
                    pressing = 1'b0;
                    btn      = 1'b0;
                    gap_left = $urandom_range(0, 12);
                end else begin
                    btn = 1'b1;
                    press_len++;
                end
            end else if (gap_left > 0) begin
                btn = ($urandom_range(0, 19) == 0);
                gap_left--;
            end else begin
                pressing  = 1'b1;
                press_len = 1;
                btn       = 1'b1;
                case ($urandom_range(0, 9))
                    0, 1:    press_goal = (thr > 0) ? thr - 1 : 0;  // just short
                    8:       press_goal = 0;
                    9:       press_goal = phase_sets[p].long_ok ? 260 : thr + 3;
                    default: press_goal = thr + $urandom_range(0, 2);
                endcase
            end
            send_tick(btn, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        restore_defaults();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].reload) begin
                drain_outputs();
                load_settings(phase_sets[0]);
            end
            send_tick(DIRECTED_ROWS[i].pressed, DIRECTED_ROWS[i].typed,
                      '{DIRECTED_ROWS[i].duty, DIRECTED_ROWS[i].mode});
        end

        // random phases, registers reloaded only with the block drained
        for (int p = 1; p < NUM_PHASES; p++) begin
            drain_outputs();
            load_settings(phase_sets[p]);
            sender_gaps   = !phase_sets[p].quiet;
            receiver_gaps = !phase_sets[p].quiet;
            run_phase(p);
        end

        // wait out the pipeline, any late extra result is caught by the checker
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- led_heartbeat_pwm_sequencer_core.f -----
+incdir+rtl/core
rtl/core/lhps_pkg.sv
rtl/core/lhps_cfg_regs.sv
rtl/core/lhps_seq.sv
rtl/core/led_heartbeat_pwm_sequencer_core.sv
sim/led_heartbeat_pwm_sequencer_core_test.sv
